@@ hdl/frame_chunk_reorder_macros.svh @@
// ----------------------------------------------------------------------------
// frame_chunk_reorder_macros: assertion helpers
// Concurrent checks sampled on the rising clock edge, masked during reset.
// ----------------------------------------------------------------------------
`ifndef FRAME_CHUNK_REORDER_MACROS_SVH
`define FRAME_CHUNK_REORDER_MACROS_SVH

// Same-cycle implication.
`define FRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame_chunk_reorder: same-cycle check failed");

// Next-cycle implication.
`define FRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame_chunk_reorder: next-cycle check failed");

`endif

@@ hdl/frc_pkg.sv @@
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types and constants of the frame chunk reorder block.
// ----------------------------------------------------------------------------
package frc_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 8;
  localparam logic [15:0] HEADER_BYTES     = 16'(2 + 2 + 2 + 2 + 2 + 2 + 2);
  localparam logic [15:0] FORMAT_OK        = 16'd1;

  typedef enum logic [1:0] {
    ACT_DRAW = 2'd0,
    ACT_ACK  = 2'd1,
    ACT_DONE = 2'd2
  } action_e;

  // one buffered chunk
  typedef struct packed {
    logic [15:0] row;
    logic [15:0] rows;
    logic [15:0] chunk;
  } frc_entry_t;

  typedef struct packed {
    logic [15:0] stream_tag;
    logic [15:0] payload_bytes;
    logic [31:0] sequence_no;
    logic [15:0] frame_w;
    logic [15:0] frame_h;
    logic [15:0] chunk_number;
    logic [15:0] chunk_total;
    logic [15:0] pixel_format;
    logic [15:0] first_row;
    logic [15:0] row_count;
  } frc_item_t;

  typedef struct packed {
    action_e     action;
    logic [15:0] chunk;
    logic [15:0] row;
    logic [15:0] rows;
    logic [15:0] width;
    logic [31:0] sequence_no;
  } frc_result_t;

  // sequencer -> cell chain
  typedef struct packed {
    logic wr_en;  // append at slot held_count
    logic take;   // remove the first matching entry, close up the rest
  } frc_chain_ctrl_t;

endpackage

@@ hdl/frc_cell.sv @@
// ----------------------------------------------------------------------------
// frc_cell
// One reorder slot: holds a chunk entry, loads it or takes its neighbor's.
// ----------------------------------------------------------------------------
module frc_cell (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  frc_pkg::frc_entry_t wr_data_i,
  input  logic              shift_i,
  input  frc_pkg::frc_entry_t next_i,
  input  logic [15:0]       expected_i,
  output frc_pkg::frc_entry_t entry_o,
  output logic              match_o
);
  import frc_pkg::*;

  frc_entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= wr_data_i;
    end else if (shift_i) begin
      entry_q <= next_i;
    end
  end

  assign entry_o = entry_q;
  assign match_o = (entry_q.row == expected_i);

endmodule

@@ hdl/frc_chain.sv @@
// ----------------------------------------------------------------------------
// frc_chain
// Row of reorder cells with oldest-first match select and close-up shift.
// ----------------------------------------------------------------------------
module frc_chain #(
  parameter int unsigned DEPTH = frc_pkg::BUFFER_DEPTH_DEF,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1),
  parameter int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk_i,
  input  frc_pkg::frc_chain_ctrl_t ctrl_i,
  input  logic [CNT_W-1:0]       count_i,
  input  logic [15:0]            expected_i,
  input  frc_pkg::frc_entry_t    wr_data_i,
  output logic                   hit_o,
  output frc_pkg::frc_entry_t    hit_entry_o
);
  import frc_pkg::*;

  frc_entry_t       entries [DEPTH];
  logic [DEPTH-1:0] match_raw;
  logic [DEPTH-1:0] match_occ;
  logic [IDX_W-1:0] hit_idx;

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    frc_entry_t next_entry;
    logic       wr_en;
    logic       shift;

    if (j == DEPTH - 1) begin : g_tail
      assign next_entry = entries[j];
    end else begin : g_body
      assign next_entry = entries[j+1];
    end

    assign wr_en        = ctrl_i.wr_en && (count_i == CNT_W'(j));
    assign shift        = ctrl_i.take && hit_o && (IDX_W'(j) >= hit_idx);
    assign match_occ[j] = match_raw[j] && (CNT_W'(j) < count_i);

    frc_cell u_cell (
      .clk_i     (clk_i),
      .wr_en_i   (wr_en),
      .wr_data_i (wr_data_i),
      .shift_i   (shift),
      .next_i    (next_entry),
      .expected_i(expected_i),
      .entry_o   (entries[j]),
      .match_o   (match_raw[j])
    );
  end

  // oldest matching slot wins
  always_comb begin
    hit_idx = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (match_occ[k]) begin
        hit_idx = IDX_W'(k);
      end
    end
  end

  assign hit_o       = |match_occ;
  assign hit_entry_o = entries[hit_idx];

endmodule

@@ hdl/frame_chunk_reorder.sv @@
// ----------------------------------------------------------------------------
// frame_chunk_reorder
// Reorders frame-chunk descriptors by row and emits draw, ack and frame-done
// items. Input and output are valid/ready channels; each field is a port.
// The frame stream id is to be written through cfg_we_i/cfg_wdata_i only
// while idle; the block itself does not enforce this. An item is taken only
// while the sequencer is idle: one item at a time. A filtered or mismatched
// item causes no result. An in-order item also drains the buffered chunks
// that follow it: the drain loop does one buffer scan per cycle, a parallel
// compare over the cell chain, and holds on a hit while the receiver stalls.
// An item causes up to BUFFER_DEPTH + 3 results.
// Results go through a staging register (to know which one is last) and an
// output register, so a stalled receiver just freezes the sequencer.
// Reset clears the frame state, the stream id and the valid flags of both
// output stages; the buffered entries themselves are never cleared, only
// the fill count.
// ----------------------------------------------------------------------------
`include "frame_chunk_reorder_macros.svh"

module frame_chunk_reorder #(
  parameter int unsigned BUFFER_DEPTH = frc_pkg::BUFFER_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // chunk items in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] stream_tag_i,
  input  logic [15:0] payload_bytes_i,
  input  logic [31:0] sequence_no_i,
  input  logic [15:0] frame_w_i,
  input  logic [15:0] frame_h_i,
  input  logic [15:0] chunk_number_i,
  input  logic [15:0] chunk_total_i,
  input  logic [15:0] pixel_format_i,
  input  logic [15:0] first_row_i,
  input  logic [15:0] row_count_i,
  // result items out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  action_o,
  output logic [15:0] out_chunk_o,
  output logic [15:0] out_row_o,
  output logic [15:0] out_rows_o,
  output logic [15:0] out_width_o,
  output logic [31:0] out_sequence_o,
  output logic        last_o
);
  import frc_pkg::*;

  localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,  // filter, header match, first draw or buffering
    S_ACK   = 6'b000100,  // ack after an in-order draw
    S_DRAIN = 6'b001000,  // one buffer scan per cycle, held while a hit waits on the receiver
    S_DONE  = 6'b010000,  // frame complete test
    S_FLUSH = 6'b100000   // push the staged result marked last
  } state_e;

  state_e          state_q, state_d;
  frc_item_t       item_q;
  logic [15:0]     cfg_id_q;
  logic            active_q, active_d;
  logic [15:0]     width_q, width_d;
  logic [15:0]     height_q, height_d;
  logic [15:0]     total_q, total_d;
  logic [15:0]     counted_q, counted_d;
  logic [15:0]     expected_q, expected_d;
  logic [CNT_W-1:0] count_q, count_d;
  frc_result_t     pend_q, pend_d;
  logic            pend_valid_q, pend_valid_d;
  frc_result_t     out_q;
  logic            out_last_q;
  logic            out_valid_q;

  // staged result -> output register
  logic            push;
  logic            push_last;
  logic            can_load;

  frc_chain_ctrl_t chain_ctrl;
  logic            hit;
  frc_entry_t      hit_entry;
  frc_entry_t      wr_entry;

  logic            filter_ok;
  logic            mismatch;
  logic            done_cond;
  logic [15:0]     eff_w, eff_h, eff_t;

  assign can_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  assign filter_ok = (item_q.stream_tag == cfg_id_q)
                  && (item_q.payload_bytes > HEADER_BYTES)
                  && (item_q.frame_w != '0) && (item_q.frame_h != '0)
                  && (item_q.chunk_total != '0)
                  && (item_q.chunk_number < item_q.chunk_total)
                  && (item_q.pixel_format == FORMAT_OK);

  // before the first good chunk the header latches itself, so no mismatch
  assign eff_w    = active_q ? width_q  : item_q.frame_w;
  assign eff_h    = active_q ? height_q : item_q.frame_h;
  assign eff_t    = active_q ? total_q  : item_q.chunk_total;
  assign mismatch = (item_q.frame_w != eff_w) || (item_q.frame_h != eff_h)
                 || (item_q.chunk_total != eff_t);

  assign done_cond = (counted_q >= total_q) && (expected_q >= height_q)
                  && (count_q == '0);

  assign wr_entry = '{row: item_q.first_row, rows: item_q.row_count,
                      chunk: item_q.chunk_number};

  always_comb begin
    state_d      = state_q;
    active_d     = active_q;
    width_d      = width_q;
    height_d     = height_q;
    total_d      = total_q;
    counted_d    = counted_q;
    expected_d   = expected_q;
    count_d      = count_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    push         = 1'b0;
    push_last    = 1'b0;
    chain_ctrl   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        if (!filter_ok) begin
          state_d = S_IDLE;
        end else if (mismatch) begin
          // header disagrees with the frame: drop everything
          active_d   = 1'b0;
          width_d    = '0;
          height_d   = '0;
          total_d    = '0;
          counted_d  = '0;
          expected_d = '0;
          count_d    = '0;
          state_d    = S_IDLE;
        end else begin
          active_d  = 1'b1;
          width_d   = eff_w;
          height_d  = eff_h;
          total_d   = eff_t;
          counted_d = (counted_q != 16'hFFFF) ? 16'(counted_q + 16'd1) : counted_q;
          if (item_q.first_row == expected_q) begin
            pend_d       = '{ACT_DRAW, item_q.chunk_number, item_q.first_row,
                             item_q.row_count, item_q.frame_w, 32'd0};
            pend_valid_d = 1'b1;
            expected_d   = 16'(item_q.first_row + item_q.row_count);
            state_d      = S_ACK;
          end else if (count_q < CNT_W'(BUFFER_DEPTH)) begin
            chain_ctrl.wr_en = 1'b1;
            count_d          = CNT_W'(count_q + 1'b1);
            pend_d           = '{ACT_ACK, item_q.chunk_number, 16'd0, 16'd0,
                                 16'd0, item_q.sequence_no};
            pend_valid_d     = 1'b1;
            state_d          = S_DONE;
          end else begin
            // buffer full: no ack, but the chunk still counts
            state_d = S_DONE;
          end
        end
      end

      S_ACK: begin
        if (can_load) begin
          push    = 1'b1;
          pend_d  = '{ACT_ACK, item_q.chunk_number, 16'd0, 16'd0, 16'd0,
                      item_q.sequence_no};
          state_d = S_DRAIN;
        end
      end

      S_DRAIN: begin
        if (!hit) begin
          state_d = S_DONE;
        end else if (can_load) begin
          push            = pend_valid_q;
          chain_ctrl.take = 1'b1;
          pend_d          = '{ACT_DRAW, hit_entry.chunk, hit_entry.row,
                              hit_entry.rows, width_q, 32'd0};
          pend_valid_d    = 1'b1;
          expected_d      = 16'(hit_entry.row + hit_entry.rows);
          count_d         = CNT_W'(count_q - 1'b1);
        end
      end

      S_DONE: begin
        if (!done_cond) begin
          state_d = S_FLUSH;
        end else if (can_load) begin
          push         = pend_valid_q;
          pend_d       = '{ACT_DONE, 16'd0, 16'd0, 16'd0, 16'd0, item_q.sequence_no};
          pend_valid_d = 1'b1;
          active_d     = 1'b0;
          width_d      = '0;
          height_d     = '0;
          total_d      = '0;
          counted_d    = '0;
          expected_d   = '0;
          count_d      = '0;
          state_d      = S_FLUSH;
        end
      end

      S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (can_load) begin
          push         = 1'b1;
          push_last    = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  frc_chain #(
    .DEPTH(BUFFER_DEPTH),
    .CNT_W(CNT_W),
    .IDX_W(IDX_W)
  ) u_chain (
    .clk_i      (clk_i),
    .ctrl_i     (chain_ctrl),
    .count_i    (count_q),
    .expected_i (expected_q),
    .wr_data_i  (wr_entry),
    .hit_o      (hit),
    .hit_entry_o(hit_entry)
  );

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_id_q <= '0;
    end else if (cfg_we_i) begin
      cfg_id_q <= cfg_wdata_i;
    end
  end

  // captured input item
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{stream_tag_i, payload_bytes_i, sequence_no_i, frame_w_i,
                  frame_h_i, chunk_number_i, chunk_total_i, pixel_format_i,
                  first_row_i, row_count_i};
    end
  end

  // sequencer and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      active_q     <= 1'b0;
      width_q      <= '0;
      height_q     <= '0;
      total_q      <= '0;
      counted_q    <= '0;
      expected_q   <= '0;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      active_q     <= active_d;
      width_q      <= width_d;
      height_q     <= height_d;
      total_q      <= total_d;
      counted_q    <= counted_d;
      expected_q   <= expected_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q      <= pend_q;
      out_last_q <= push_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = out_q.action;
  assign out_chunk_o    = out_q.chunk;
  assign out_row_o      = out_q.row;
  assign out_rows_o     = out_q.rows;
  assign out_width_o    = out_q.width;
  assign out_sequence_o = out_q.sequence_no;
  assign last_o         = out_last_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `FRC_ASSERT_IMPL(a_idle_no_staged, clk_i, rst_ni, in_ready_o, !pend_valid_q)
  `FRC_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(BUFFER_DEPTH))
  `FRC_ASSERT_IMPL(a_inactive_clear, clk_i, rst_ni, !active_q,
                   (count_q == '0) && (expected_q == '0) && (counted_q == '0))
  `FRC_ASSERT_IMPL(a_done_is_last, clk_i, rst_ni,
                   out_valid_q && (out_q.action == ACT_DONE), out_last_q)
  `FRC_ASSERT_NEXT(a_check_follows_accept, clk_i, rst_ni, in_valid_i && in_ready_o,
                   state_q == S_CHECK)

endmodule
